// ===== src/skcc_pkg.sv =====
// shared constants and helpers for the canonical k-mer counter
// no dependencies; imported by small_kmer_canonical_counter
package skcc_pkg;

  localparam int MAX_K       = 8;
  localparam int KMER_W      = 2 * MAX_K;
  localparam int TABLE_AW    = KMER_W;
  localparam int COUNT_W     = 32;
  localparam int RUN_W       = 4;
  localparam int KLEN_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [RUN_W-1:0]     RUN_MAX = '1;
  localparam logic [KLEN_W-1:0]    K_MAX   = KLEN_W'(MAX_K);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE_REPEATS = 2'd2;

  // previous symbol codes
  localparam logic [2:0] PREV_NONE = 3'd0;
  localparam logic [2:0] PREV_N    = 3'd5;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic [KMER_W-1:0] kmer_t;

  // low 2k bits set
  function automatic kmer_t pair_span_bits(input logic [KLEN_W-1:0] k);
    kmer_t m;
    m = '0;
    for (int i = 0; i < KMER_W; i++) begin
      m[i] = (i < 2 * int'(k));
    end
    return m;
  endfunction

endpackage

// ===== src/small_kmer_canonical_counter.sv =====
// canonical k-mer counter: k-mer shift registers, histogram table in a
// synchronous ram with read-modify-write and one-deep write forwarding
// depends on skcc_pkg
//
// an accepted word passes the lookup stage register and then the output register
// throughput: one word per cycle while out_ready is high, set by the single table ram
// read and write port; reset: synchronous, active low; afterwards the table is cleared
// one entry a cycle with in_ready low; configuration writes are taken throughout
module small_kmer_canonical_counter
  import skcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KLEN_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [1:0]           in_base,
  input  logic                 in_is_unknown,
  input  logic                 in_first_of_read,
  input  logic [15:0]          in_read_index,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_counted,
  output logic [15:0]          out_kmer_index,
  output logic [COUNT_W-1:0]   out_entry_count,
  output logic [COUNT_W-1:0]   out_total_count
);

  // configuration
  logic [KLEN_W-1:0] klen_r;
  logic              canon_r;
  logic              collapse_r;

  // stream state
  kmer_t             fwd_r, fwd_nxt;
  kmer_t             rev_r, rev_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [2:0]        prev_r, prev_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;

  // table clear sweep
  logic                clear_r;
  logic [TABLE_AW-1:0] clr_addr_r;

  // lookup stage
  logic                s1_valid_r;
  logic                s1_cnt_r;
  logic                s1_rd_r;
  logic [TABLE_AW-1:0] s1_key_r;
  logic [COUNT_W-1:0]  s1_total_r;
  logic                s1_adv;

  // last table write, for forwarding
  logic                wr_valid_r;
  logic [TABLE_AW-1:0] wr_addr_r;
  logic [COUNT_W-1:0]  wr_data_r;

  // output register
  logic                out_valid_r;
  logic                out_counted_r;
  logic [15:0]         out_index_r;
  logic [COUNT_W-1:0]  out_entry_r;
  logic [COUNT_W-1:0]  out_total_r;

  // table ram
  logic [COUNT_W-1:0]  tbl_mem [2**TABLE_AW];
  logic [COUNT_W-1:0]  rd_data_r;
  logic                mem_re;
  logic [TABLE_AW-1:0] mem_ra;
  logic                mem_we;
  logic [TABLE_AW-1:0] mem_wa;
  logic [COUNT_W-1:0]  mem_wd;

  // front end
  logic                accept;
  logic                feed;
  logic [KLEN_W-1:0]   k_eff;
  logic [KLEN_W-1:0]   k_m1;
  kmer_t               kmask;
  kmer_t               fwd_base, rev_base;
  logic [RUN_W-1:0]    run_base;
  logic [2:0]          prev_base;
  logic [2:0]          code;
  logic [1:0]          sym;
  logic                drop;
  logic                cnt_hit;
  kmer_t               key;
  kmer_t               rev_top;
  logic [COUNT_W-1:0]  cur_entry;
  logic [COUNT_W-1:0]  inc_entry;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clear_r && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;
  assign feed     = accept && (in_cmd == CMD_FEED);

  always_comb begin
    if (klen_r == '0) begin
      k_eff = KLEN_W'(1);
    end else if (klen_r > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = klen_r;
    end
    k_m1  = k_eff - KLEN_W'(1);
    kmask = pair_span_bits(k_eff);

    // a read start clears the history before the base goes in
    fwd_base  = in_first_of_read ? '0 : fwd_r;
    rev_base  = in_first_of_read ? '0 : rev_r;
    run_base  = in_first_of_read ? '0 : run_r;
    prev_base = in_first_of_read ? PREV_NONE : prev_r;

    code = in_is_unknown ? PREV_N : {1'b0, in_base} + 3'd1;
    drop = collapse_r && (prev_base != PREV_NONE) && (code == prev_base);
    sym  = in_is_unknown ? 2'd0 : in_base;

    rev_top = kmer_t'(2'd3 - sym) << {k_m1, 1'b0};

    fwd_nxt  = fwd_r;
    rev_nxt  = rev_r;
    run_nxt  = run_r;
    prev_nxt = prev_r;
    total_nxt = total_r;
    cnt_hit  = 1'b0;
    if (feed && !drop) begin
      fwd_nxt  = ((fwd_base << 2) | kmer_t'(sym)) & kmask;
      rev_nxt  = (((rev_base & kmask) >> 2) | rev_top) & kmask;
      prev_nxt = code;
      if (in_is_unknown) begin
        run_nxt = '0;
      end else if (run_base == RUN_MAX) begin
        run_nxt = run_base;
      end else begin
        run_nxt = run_base + RUN_W'(1);
      end
      cnt_hit = (run_nxt >= k_eff);
      if (cnt_hit) begin
        total_nxt = total_r + COUNT_W'(1);
      end
    end

    key = (canon_r && (rev_nxt < fwd_nxt)) ? rev_nxt : fwd_nxt;

    mem_re = accept;
    mem_ra = (in_cmd == CMD_READ) ? in_read_index[TABLE_AW-1:0] : key;

    // forward the previous write, which the ram read of this word missed
    cur_entry = (wr_valid_r && (wr_addr_r == s1_key_r)) ? wr_data_r : rd_data_r;
    inc_entry = cur_entry + COUNT_W'(1);

    mem_we = clear_r || (s1_adv && s1_cnt_r);
    mem_wa = clear_r ? clr_addr_r : s1_key_r;
    mem_wd = clear_r ? '0 : inc_entry;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r      <= K_MAX;
      canon_r     <= 1'b1;
      collapse_r  <= 1'b0;
      fwd_r       <= '0;
      rev_r       <= '0;
      run_r       <= '0;
      prev_r      <= PREV_NONE;
      total_r     <= '0;
      clear_r     <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KMER_LENGTH:      klen_r     <= cfg_wdata;
          CFG_CANONICAL_MODE:   canon_r    <= cfg_wdata[0];
          CFG_COLLAPSE_REPEATS: collapse_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      fwd_r   <= fwd_nxt;
      rev_r   <= rev_nxt;
      run_r   <= run_nxt;
      prev_r  <= prev_nxt;
      total_r <= total_nxt;

      if (clear_r) begin
        clr_addr_r <= clr_addr_r + TABLE_AW'(1);
        if (clr_addr_r == '1) begin
          clear_r <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (clear_r) begin
        wr_valid_r <= 1'b0;
      end else if (s1_adv && s1_cnt_r) begin
        wr_valid_r <= 1'b1;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cnt_r   <= cnt_hit;
      s1_rd_r    <= (in_cmd == CMD_READ);
      s1_key_r   <= (in_cmd == CMD_READ) ? in_read_index[TABLE_AW-1:0] :
                    (cnt_hit ? key : '0);
      s1_total_r <= total_nxt;
    end
    if (s1_adv && s1_cnt_r) begin
      wr_addr_r <= s1_key_r;
      wr_data_r <= inc_entry;
    end
    if (s1_adv) begin
      out_counted_r <= s1_cnt_r;
      out_index_r   <= 16'(s1_key_r);
      out_total_r   <= s1_total_r;
      if (s1_cnt_r) begin
        out_entry_r <= inc_entry;
      end else if (s1_rd_r) begin
        out_entry_r <= cur_entry;
      end else begin
        out_entry_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_counted     = out_counted_r;
  assign out_kmer_index  = out_index_r;
  assign out_entry_count = out_entry_r;
  assign out_total_count = out_total_r;

  // no word enters while the table sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !accept)
    else $error("word accepted during table clear");

  // a counted k-mer bumps the total by exactly one
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_hit |=> total_r == $past(total_r) + COUNT_W'(1))
    else $error("running total not incremented");

  // a stalled lookup word keeps its key
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_key_r)))
    else $error("lookup stage lost its word under stall");

  // the sweep ends only after the last entry
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clear_r) |-> $past(clr_addr_r) == '1)
    else $error("table clear ended early");

  // sweep and increment never share the write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !(s1_adv && s1_cnt_r))
    else $error("table write port conflict");

endmodule

// ===== tb/skcc_count_checker.sv =====
// checker for the canonical k-mer counter: predicts each result word from the accepted
// input words and configuration writes, and compares it with the words the block returns
// depends on skcc_pkg
module skcc_count_checker
  import skcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KLEN_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [1:0]           in_base,
  input  logic                 in_is_unknown,
  input  logic                 in_first_of_read,
  input  logic [15:0]          in_read_index,

  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_counted,
  input  logic [15:0]          out_kmer_index,
  input  logic [COUNT_W-1:0]   out_entry_count,
  input  logic [COUNT_W-1:0]   out_total_count,

  output int                   fail_count,
  output int                   words_owed
);

  typedef struct packed {
    logic               counted;
    logic [15:0]        kmer_index;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] total_count;
  } tally_t;

  logic [KLEN_W-1:0]  k_setting;
  logic               canonical_on;
  logic               collapse_on;

  kmer_t              fwd_kmer;
  kmer_t              rc_kmer;
  logic [RUN_W-1:0]   clean_len;
  logic [2:0]         last_symbol;
  logic [COUNT_W-1:0] histogram [0:(1 << TABLE_AW) - 1];
  logic [COUNT_W-1:0] kmers_seen;

  tally_t             expected_tallies [$];
  int                 failures;

  // out-of-range lengths clamp to 1 or MAX_K
  function automatic int k_in_use();
    if (k_setting == '0) return 1;
    if (int'(k_setting) > MAX_K) return MAX_K;
    return int'(k_setting);
  endfunction

  task automatic tally_word(input logic cmd, input logic [1:0] base, input logic unk,
                            input logic first, input logic [15:0] ridx, output tally_t t);
    int          k;
    logic [2:0]  sym_code;
    logic [1:0]  sym;
    logic [1:0]  comp;
    logic [31:0] keep;
    logic [31:0] fwd_next;
    logic [31:0] rc_next;
    kmer_t       key;
    t = '0;
    t.total_count = kmers_seen;
    if (cmd == CMD_READ) begin
      t.kmer_index  = ridx;
      t.entry_count = histogram[ridx[TABLE_AW-1:0]];
    end else begin
      if (first) begin
        fwd_kmer    = '0;
        rc_kmer     = '0;
        clean_len   = '0;
        last_symbol = PREV_NONE;
      end
      sym_code = unk ? PREV_N : {1'b0, base} + 3'd1;
      // with collapse on, a repeat of the last kept symbol is dropped, N repeating N included
      if (!(collapse_on && last_symbol != PREV_NONE && sym_code == last_symbol)) begin
        last_symbol = sym_code;
        k    = k_in_use();
        keep = (32'd1 << (2 * k)) - 32'd1;
        sym  = unk ? 2'd0 : base;
        comp = 2'd3 - sym;
        fwd_next = (({16'd0, fwd_kmer} << 2) | 32'(sym)) & keep;
        rc_next  = ((({16'd0, rc_kmer} & keep) >> 2) | (32'(comp) << (2 * (k - 1)))) & keep;
        fwd_kmer = fwd_next[KMER_W-1:0];
        rc_kmer  = rc_next[KMER_W-1:0];
        if (unk) clean_len = '0;
        else if (clean_len != RUN_MAX) clean_len = clean_len + RUN_W'(1);
        if (int'(clean_len) >= k) begin
          key = (canonical_on && rc_kmer < fwd_kmer) ? rc_kmer : fwd_kmer;
          histogram[key] = histogram[key] + COUNT_W'(1);
          kmers_seen     = kmers_seen + COUNT_W'(1);
          t.counted     = 1'b1;
          t.kmer_index  = key;
          t.entry_count = histogram[key];
          t.total_count = kmers_seen;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (!rst_n) begin
      k_setting    = K_MAX;
      canonical_on = 1'b1;
      collapse_on  = 1'b0;
      fwd_kmer     = '0;
      rc_kmer      = '0;
      clean_len    = '0;
      last_symbol  = PREV_NONE;
      kmers_seen   = '0;
      foreach (histogram[i]) histogram[i] = '0;
      expected_tallies.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KMER_LENGTH:      k_setting    = cfg_wdata;
          CFG_CANONICAL_MODE:   canonical_on = cfg_wdata[0];
          CFG_COLLAPSE_REPEATS: collapse_on  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tally_word(in_cmd, in_base, in_is_unknown, in_first_of_read, in_read_index, want);
        expected_tallies.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.counted     = out_counted;
        got.kmer_index  = out_kmer_index;
        got.entry_count = out_entry_count;
        got.total_count = out_total_count;
        if (expected_tallies.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result word: counted %0d index %h entry %0d total %0d",
                     got.counted, got.kmer_index, got.entry_count, got.total_count);
        end else begin
          want = expected_tallies.pop_front();
          if (got.counted !== want.counted || got.kmer_index !== want.kmer_index ||
              got.entry_count !== want.entry_count || got.total_count !== want.total_count)
          begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected %0d %h %0d %0d, got %0d %h %0d %0d",
                       want.counted, want.kmer_index, want.entry_count, want.total_count,
                       got.counted, got.kmer_index, got.entry_count, got.total_count);
          end
        end
      end
    end
    fail_count <= failures;
    words_owed <= expected_tallies.size();
  end

endmodule

// ===== tb/tb_small_kmer_canonical_counter.sv =====
// top of the canonical k-mer counter testbench: clock, reset, configuration, stimulus
// and verdict; depends on skcc_pkg, small_kmer_canonical_counter and skcc_count_checker
module tb_small_kmer_canonical_counter
  import skcc_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [KLEN_W-1:0]    cfg_wdata        = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic                 in_cmd           = CMD_FEED;
  logic [1:0]           in_base          = BASE_A;
  logic                 in_is_unknown    = 1'b0;
  logic                 in_first_of_read = 1'b0;
  logic [15:0]          in_read_index    = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic                 out_counted;
  logic [15:0]          out_kmer_index;
  logic [COUNT_W-1:0]   out_entry_count;
  logic [COUNT_W-1:0]   out_total_count;

  int   fail_count;
  int   words_owed;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_done      = 1'b0;
  int   held           = 0;
  int   cycles         = 0;

  small_kmer_canonical_counter u_top (.*);

  skcc_count_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("small_kmer_canonical_counter verification failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off counted here
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      held      <= held + 1;
      if (held + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      if (!hold_req) begin
        held      <= 0;
        hold_done <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic cmd, input logic [1:0] base, input logic unk,
                           input logic first, input logic [15:0] ridx);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_base          <= base;
    in_is_unknown    <= unk;
    in_first_of_read <= first;
    in_read_index    <= ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic feed(input logic [1:0] base, input logic unk, input logic first);
    send_word(CMD_FEED, base, unk, first, 16'($urandom));
  endtask

  // ignored fields of a read word carry random values
  task automatic read_entry(input logic [15:0] idx);
    send_word(CMD_READ, 2'($urandom), 1'($urandom), 1'($urandom), idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [KLEN_W-1:0] k, input logic canon,
                            input logic collapse);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KMER_LENGTH;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= CFG_CANONICAL_MODE;
    cfg_wdata <= KLEN_W'(canon);
    @(posedge clk);
    cfg_index <= CFG_COLLAPSE_REPEATS;
    cfg_wdata <= KLEN_W'(collapse);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly whole reads with random content, some reads of the table and some noise
  task automatic random_reads(input int n);
    int sent;
    int len;
    int pos;
    int roll;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 30);
      for (pos = 0; pos < len && sent < n; pos++) begin
        roll = $urandom_range(99);
        if (roll < 8)
          read_entry(($urandom_range(1) != 0) ? 16'($urandom_range(255)) : 16'($urandom));
        else if (roll < 12)
          send_word(CMD_FEED, 2'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
        else
          // the first read of a phase sometimes carries on from the last phase
          feed(2'($urandom), $urandom_range(99) < 5,
               pos == 0 && (sent != 0 || $urandom_range(1) != 0));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [KLEN_W-1:0] k, input logic canon,
                           input logic collapse, input int idle, input int stall,
                           input logic hold, input int n);
    drain();
    set_config(k, canon, collapse);
    send_idle_pct  = idle;
    recv_stall_pct <= stall;
    if (hold) hold_req <= 1'b1;
    random_reads(n);
    if (hold) begin
      while (!hold_done) @(posedge clk);
      hold_req <= 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_config(4'd8, 1'b1, 1'b0);

    // no read mark yet: bases after reset form one read
    feed(BASE_T, 1'b0, 1'b0);
    feed(BASE_G, 1'b0, 1'b0);
    feed(BASE_C, 1'b0, 1'b0);
    feed(BASE_A, 1'b0, 1'b0);
    feed(BASE_T, 1'b0, 1'b0);
    feed(BASE_T, 1'b0, 1'b0);
    feed(BASE_G, 1'b0, 1'b0);
    feed(BASE_A, 1'b0, 1'b0);
    feed(BASE_C, 1'b0, 1'b0);
    feed(BASE_G, 1'b1, 1'b0);
    feed(BASE_G, 1'b0, 1'b0);
    read_entry(16'hFFFF);
    read_entry(16'h0000);

    // single-base k-mers, forward only, repeats collapsed
    drain();
    set_config(4'd1, 1'b0, 1'b1);
    feed(BASE_A, 1'b0, 1'b1);
    feed(BASE_A, 1'b0, 1'b0);
    feed(BASE_C, 1'b1, 1'b0);
    feed(BASE_T, 1'b1, 1'b0);
    feed(BASE_C, 1'b0, 1'b0);
    feed(BASE_C, 1'b0, 1'b1);
    feed(BASE_T, 1'b0, 1'b0);
    read_entry(16'd3);

    // zero length mid-read acts as one
    drain();
    set_config(4'd0, 1'b1, 1'b0);
    feed(BASE_T, 1'b0, 1'b0);
    feed(BASE_A, 1'b0, 1'b0);
    read_entry(16'd0);

    run_phase(4'd8,  1'b1, 1'b0, 0,  0,  1'b0, 250);
    run_phase(4'd1,  1'b0, 1'b1, 87, 0,  1'b0, 150);
    run_phase(4'd4,  1'b1, 1'b1, 0,  87, 1'b0, 200);
    run_phase(4'd0,  1'b1, 1'b0, 8,  8,  1'b0, 150);
    run_phase(4'd15, 1'b0, 1'b0, 8,  8,  1'b0, 150);
    run_phase(4'd3,  1'b1, 1'b0, 0,  0,  1'b1, 250);
    run_phase(4'd6,  1'b0, 1'b1, 8,  8,  1'b0, 200);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("small_kmer_canonical_counter verification clean");
    end else begin
      $display("small_kmer_canonical_counter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/skcc_pkg.sv
src/small_kmer_canonical_counter.sv
tb/skcc_count_checker.sv
tb/tb_small_kmer_canonical_counter.sv
